/* src/token_bucket_tx_shaper_core_defines.svh */
// Assertion macros shared by the shaper RTL.
`ifndef TOKEN_BUCKET_TX_SHAPER_CORE_DEFINES_SVH
`define TOKEN_BUCKET_TX_SHAPER_CORE_DEFINES_SVH

// same-cycle implication
`define TBS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/tbs_pkg.sv */
package tbs_pkg;

   localparam int CAP_W      = 24;
   localparam int RATE_W     = 34;
   localparam int FRAME_W    = 16;
   localparam int TIME_W     = 64;
   localparam int WAIT_W     = 29;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 34;

   localparam int CHUNK_W      = 16;
   localparam int NCHUNK       = 3;
   localparam int ELAP_W       = CHUNK_W * NCHUNK;
   localparam int ELAP_SAT_BIT = 47;
   localparam int PROD_W       = RATE_W + CHUNK_W;
   localparam int ACC_W        = RATE_W + ELAP_W;
   localparam int QUO_W        = WAIT_W;
   localparam int SUM_W        = QUO_W + 1;
   localparam int MCNT_W       = $clog2(NCHUNK + 1);

   localparam logic [MCNT_W-1:0]     MUL_LAST     = MCNT_W'(NCHUNK);
   localparam logic [CAP_W-1:0]      CAP_RESET    = 24'd3072;
   localparam logic [RATE_W-1:0]     RATE_RESET   = 34'd100000000;
   localparam logic [RATE_W-1:0]     BIT_US_SCALE = 34'd8000000;
   localparam logic [WAIT_W-1:0]     WAIT_MAX     = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE     = 2'd1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_bytes;
      logic [TIME_W-1:0]  now_us;
   } req_type;

   typedef struct packed {
      logic              ready_res;
      logic [WAIT_W-1:0] wait_us;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_DEBIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      MODE_REFILL,
      MODE_WAIT
   } mode_type;

endpackage

/* src/tbs_div.sv */
module tbs_div #(
   parameter int NUM_W = tbs_pkg::ACC_W,
   parameter int DEN_W = tbs_pkg::RATE_W,
   parameter int QUO_W = tbs_pkg::QUO_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [QUO_W-1:0]     quo,
   output tbs_pkg::div_stat_type stat
);

   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam int HI_W  = NUM_W - QUO_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sat_ff, sat_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   logic [HI_W-1:0]  hi;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign hi    = num[NUM_W-1:QUO_W];
   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         den_in = den;
         quo_in = '0;
         if (hi >= {{(HI_W - DEN_W){1'b0}}, den}) begin
            sat_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            sat_in  = 1'b0;
            rem_in  = hi[DEN_W-1:0];
            low_in  = num[QUO_W-1:0];
            cnt_in  = CNT_W'(QUO_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         low_in = low_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         sat_ff  <= sat_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign quo       = quo_ff;
   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;

endmodule

/* src/token_bucket_tx_shaper_core.sv */
// Sequence: an accepted word goes from ST_DEBIT to ST_DONE when no refill math is needed and
// the frame fits; otherwise the refill and the wait each go through ST_MUL, the iterative
// 34x16 multiplier, and then ST_START and ST_DIV, the 29-step shared restoring divider.
// Handshake: req_stall is high from accept until the result
// is in the output register, which frees the input while rsp waits.
// Reset: capacity 3072, rate 100000000, bucket full, clock not started.
`include "token_bucket_tx_shaper_core_defines.svh"

module token_bucket_tx_shaper_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tbs_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tbs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tbs_pkg::state_type state_ff, state_in;
   tbs_pkg::mode_type  mode_ff, mode_in;

   logic [tbs_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic [tbs_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [tbs_pkg::CAP_W-1:0]   token_ff, token_in;
   logic [tbs_pkg::TIME_W-1:0]  last_ff, last_in;
   logic [tbs_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [tbs_pkg::MCNT_W-1:0]  mcnt_ff, mcnt_in;
   logic [tbs_pkg::RATE_W-1:0]  a_ff, a_in;
   logic [tbs_pkg::ELAP_W-1:0]  b_ff, b_in;
   logic [tbs_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [tbs_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                        ready_ff, ready_in;
   logic [tbs_pkg::WAIT_W-1:0]  wait_ff, wait_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tbs_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        later;
   logic [tbs_pkg::TIME_W-1:0]  elapsed;
   logic [tbs_pkg::SUM_W-1:0]   refill_sum;
   logic [tbs_pkg::FRAME_W-1:0] deficit;
   logic                        div_start;
   logic [tbs_pkg::RATE_W-1:0]  div_den;
   logic [tbs_pkg::QUO_W-1:0]   div_quo;
   tbs_pkg::div_stat_type       div_stat;

   assign req_stall  = (state_ff != tbs_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign elapsed    = req_data.now_us - last_ff;
   assign later      = req_data.now_us > last_ff;
   assign refill_sum = tbs_pkg::SUM_W'(token_ff) + tbs_pkg::SUM_W'(div_quo);
   assign deficit    = frame_ff - token_ff[tbs_pkg::FRAME_W-1:0];
   assign div_den    = (mode_ff == tbs_pkg::MODE_REFILL) ? tbs_pkg::BIT_US_SCALE : rate_ff;

   tbs_div #(
      .NUM_W(tbs_pkg::ACC_W),
      .DEN_W(tbs_pkg::RATE_W),
      .QUO_W(tbs_pkg::QUO_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (acc_ff),
      .den  (div_den),
      .quo  (div_quo),
      .stat (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cap_in       = cap_ff;
      rate_in      = rate_ff;
      token_in     = token_ff;
      last_in      = last_ff;
      frame_in     = frame_ff;
      mcnt_in      = mcnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      ready_in     = ready_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         tbs_pkg::ST_IDLE: begin
            if (accept) begin
               frame_in = req_data.frame_bytes;
               last_in  = req_data.now_us;
               state_in = tbs_pkg::ST_DEBIT;
               if (last_ff != '0 && later && rate_ff != '0) begin
                  if (elapsed[tbs_pkg::TIME_W-1:tbs_pkg::ELAP_SAT_BIT] != '0) begin
                     token_in = cap_ff;
                  end else begin
                     a_in     = rate_ff;
                     b_in     = elapsed[tbs_pkg::ELAP_W-1:0];
                     mode_in  = tbs_pkg::MODE_REFILL;
                     mcnt_in  = '0;
                     state_in = tbs_pkg::ST_MUL;
                  end
               end
            end
         end
         tbs_pkg::ST_MUL: begin
            prod_in = a_ff * b_ff[tbs_pkg::ELAP_W-1 -: tbs_pkg::CHUNK_W];
            b_in    = b_ff << tbs_pkg::CHUNK_W;
            acc_in  = (mcnt_ff == '0) ? '0
                    : (acc_ff << tbs_pkg::CHUNK_W) + tbs_pkg::ACC_W'(prod_ff);
            mcnt_in = mcnt_ff + tbs_pkg::MCNT_W'(1);
            if (mcnt_ff == tbs_pkg::MUL_LAST) begin
               state_in = tbs_pkg::ST_START;
            end
         end
         tbs_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = tbs_pkg::ST_DIV;
         end
         tbs_pkg::ST_DIV: begin
            if (div_stat.done) begin
               if (mode_ff == tbs_pkg::MODE_REFILL) begin
                  if (div_stat.sat || refill_sum > tbs_pkg::SUM_W'(cap_ff)) begin
                     token_in = cap_ff;
                  end else begin
                     token_in = refill_sum[tbs_pkg::CAP_W-1:0];
                  end
                  state_in = tbs_pkg::ST_DEBIT;
               end else begin
                  if (div_stat.sat) begin
                     wait_in  = tbs_pkg::WAIT_MAX;
                     ready_in = 1'b0;
                  end else begin
                     wait_in  = div_quo;
                     ready_in = (div_quo == '0);
                     if (div_quo == '0) begin
                        token_in = '0;
                     end
                  end
                  state_in = tbs_pkg::ST_DONE;
               end
            end
         end
         tbs_pkg::ST_DEBIT: begin
            if (tbs_pkg::CAP_W'(frame_ff) <= token_ff) begin
               token_in = token_ff - tbs_pkg::CAP_W'(frame_ff);
               ready_in = 1'b1;
               wait_in  = '0;
               state_in = tbs_pkg::ST_DONE;
            end else begin
               a_in     = tbs_pkg::BIT_US_SCALE;
               b_in     = tbs_pkg::ELAP_W'(deficit);
               mode_in  = tbs_pkg::MODE_WAIT;
               mcnt_in  = '0;
               state_in = tbs_pkg::ST_MUL;
            end
         end
         tbs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.ready_res = ready_ff;
               rsp_data_in.wait_us   = wait_ff;
               state_in              = tbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbs_pkg::ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         priority if (csr_index == tbs_pkg::CSR_CAPACITY) begin
            cap_in   = csr_wdata[tbs_pkg::CAP_W-1:0];
            token_in = csr_wdata[tbs_pkg::CAP_W-1:0];
            last_in  = '0;
         end else if (csr_index == tbs_pkg::CSR_RATE) begin
            rate_in  = csr_wdata[tbs_pkg::RATE_W-1:0];
            token_in = cap_ff;
            last_in  = '0;
         end else begin
            cap_in = cap_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbs_pkg::ST_IDLE;
         mode_ff      <= tbs_pkg::MODE_REFILL;
         cap_ff       <= tbs_pkg::CAP_RESET;
         rate_ff      <= tbs_pkg::RATE_RESET;
         token_ff     <= tbs_pkg::CAP_RESET;
         last_ff      <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cap_ff       <= cap_in;
         rate_ff      <= rate_in;
         token_ff     <= token_in;
         last_ff      <= last_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      ready_ff    <= ready_in;
      wait_ff     <= wait_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TBS_ASSERT_SAME(a_token_le_cap, clock, reset, 1'b1, token_ff <= cap_ff, "token count above capacity")
   `TBS_ASSERT_SAME(a_grant_no_wait, clock, reset, rsp_valid_ff && rsp_data_ff.ready_res, rsp_data_ff.wait_us == '0, "granted word carries a wait")
   `TBS_ASSERT_SAME(a_div_done_state, clock, reset, div_stat.done, state_ff == tbs_pkg::ST_DIV, "divider finished outside divide state")
   `TBS_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != tbs_pkg::ST_IDLE, "accepted word left sequencer idle")

endmodule
